@@ rtl/tndq_pkg.sv @@
// tndq_pkg: shared types and constants of the timed note delay queue
// no dependencies; imported by tndq_out_stage and timed_note_delay_queue
package tndq_pkg;

    localparam logic [7:0] TYPE_NOTE_ON  = 8'h90;
    localparam logic [7:0] TYPE_NOTE_OFF = 8'h80;

    typedef enum logic [1:0] {
        KIND_OFF  = 2'd0,
        KIND_ON   = 2'd1,
        KIND_FULL = 2'd2
    } event_kind_t;

    // one result item as it travels from the control logic to the output stage
    typedef struct packed {
        event_kind_t kind;
        logic [4:0]  chan;
        logic [7:0]  note;
        logic [7:0]  velocity;
    } evt_t;

endpackage

@@ rtl/tndq_req_if.sv @@
// tndq_req_if: request channel (enqueue or tick) with valid/ready handshake
// standalone interface, no package dependency
interface tndq_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  message_type;
    logic [3:0]  chan;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [31:0] delay_amount;

    modport source (
        output valid, req_type, message_type, chan, first_data, second_data, delay_amount,
        input  ready
    );
    modport sink (
        input  valid, req_type, message_type, chan, first_data, second_data, delay_amount,
        output ready
    );
endinterface

@@ rtl/tndq_evt_if.sv @@
// tndq_evt_if: result channel (released note or dropped enqueue) with valid/ready
// standalone interface, no package dependency
interface tndq_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [4:0] chan_out;
    logic [7:0] note_out;
    logic [7:0] velocity_out;

    modport source (
        output valid, event_kind, chan_out, note_out, velocity_out,
        input  ready
    );
    modport sink (
        input  valid, event_kind, chan_out, note_out, velocity_out,
        output ready
    );
endinterface

@@ rtl/tndq_ring_mem.sv @@
// tndq_ring_mem: single-port-write, registered-read ring storage
// no package dependency; used by timed_note_delay_queue
module tndq_ring_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 60
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/tndq_out_stage.sv @@
// tndq_out_stage: output register that decouples result delivery from the queue logic
// depends on tndq_pkg and tndq_evt_if
module tndq_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tndq_pkg::evt_t push_data,
    output logic           can_take,
    tndq_evt_if.source     evt
);
    import tndq_pkg::*;

    logic valid_reg;
    logic valid_next;
    evt_t data_reg;

    // free when empty or when the held item leaves this cycle
    assign can_take = !valid_reg || evt.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (evt.ready)
        begin
            valid_next = 1'b0;
        end
        if (push && can_take)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && can_take)
        begin
            data_reg <= push_data;
        end
    end

    assign evt.valid        = valid_reg;
    assign evt.event_kind   = data_reg.kind;
    assign evt.chan_out     = data_reg.chan;
    assign evt.note_out     = data_reg.note;
    assign evt.velocity_out = data_reg.velocity;

endmodule

@@ rtl/timed_note_delay_queue.sv @@
// timed_note_delay_queue: top level of the timestamped note delay queue
// depends on tndq_pkg, tndq_req_if, tndq_evt_if, tndq_ring_mem, tndq_out_stage
//
// A first-in first-out ring of QUEUE_DEPTH delayed music messages held in one
// synchronous memory. An enqueue item writes type, channel, both data bytes and
// a due time (tick counter plus delay, wrapping at TIME_BITS bits) at the tail
// slot in the cycle it is accepted; a full ring drops it and reports an item
// with event kind "full" and zero payload. A tick item advances the tick
// counter and, if the ring holds anything, reads the head entry; in the next
// cycle the due time is compared unsigned against the counter, and a due head
// is popped. Note-on and note-off entries give a result item with a one-based
// channel, other types leave silently. At most one entry leaves per tick.
// An enqueue that is stored and a tick on an empty ring keep the input ready;
// a tick whose head is not yet due or leaves silently passes the check state
// (memory read), a dropped enqueue the pending state (hand-off to the output
// register), and a tick that releases a note both, check then pending. The
// output register lets new items enter while a result still waits for the
// consumer; a further result holds the input until the waiting one is taken.
// Memory contents need no reset: only entries between head and tail are ever
// read.
module timed_note_delay_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    tndq_req_if.sink   req,
    tndq_evt_if.source evt
);
    import tndq_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = 8 + 4 + 8 + 8 + TIME_BITS;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,   // waiting for an item
        ST_CHECK,  // head entry arrives from memory, compare due time
        ST_PEND    // result waits for the output register
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_reg;
    logic [IDX_W-1:0]     tail_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [TIME_BITS-1:0] tick_reg;
    logic [TIME_BITS-1:0] tick_next;
    evt_t                 pend_reg;
    evt_t                 pend_next;

    logic                 accept;
    logic                 is_full;
    logic                 mem_wr_en;
    logic [ENTRY_W-1:0]   mem_wr_data;
    logic                 mem_rd_en;
    logic [ENTRY_W-1:0]   mem_rd_data;
    logic                 out_push;
    logic                 out_can_take;

    // fields of the head entry as read back
    logic [7:0]           head_type;
    logic [3:0]           head_chan;
    logic [7:0]           head_d1;
    logic [7:0]           head_d2;
    logic [TIME_BITS-1:0] head_due;
    logic                 head_is_note;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == FULL_CNT);

    // entry layout: type, channel, note, velocity, due time
    assign mem_wr_data = {req.message_type, req.chan, req.first_data, req.second_data,
                          tick_reg + TIME_BITS'(req.delay_amount)};
    assign mem_wr_en   = accept && !req.req_type && !is_full;
    assign mem_rd_en   = accept && req.req_type && (count_reg != '0);

    assign {head_type, head_chan, head_d1, head_d2, head_due} = mem_rd_data;
    assign head_is_note = (head_type == TYPE_NOTE_ON) || (head_type == TYPE_NOTE_OFF);

    assign out_push = (state_reg == ST_PEND);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        tick_next  = tick_reg;
        pend_next  = pend_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type)
                    begin
                        // tick: counter moves first, then the head is checked
                        tick_next = tick_reg + TIME_BITS'(1);
                        if (count_reg != '0)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    else if (is_full)
                    begin
                        // dropped enqueue, report with zero payload
                        pend_next.kind     = KIND_FULL;
                        pend_next.chan     = '0;
                        pend_next.note     = '0;
                        pend_next.velocity = '0;
                        state_next         = ST_PEND;
                    end
                    else
                    begin
                        tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                state_next = ST_IDLE;
                if (tick_reg >= head_due)
                begin
                    head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    if (head_is_note)
                    begin
                        pend_next.kind     = (head_type == TYPE_NOTE_ON) ? KIND_ON : KIND_OFF;
                        pend_next.chan     = {1'b0, head_chan} + 5'd1;
                        pend_next.note     = head_d1;
                        pend_next.velocity = head_d2;
                        state_next         = ST_PEND;
                    end
                end
            end
            ST_PEND:
            begin
                // leave once the output register has taken the item
                if (out_can_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            tick_reg  <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
            pend_reg  <= pend_next;
        end
    end

    tndq_ring_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (tail_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data)
    );

    tndq_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (pend_reg),
        .can_take  (out_can_take),
        .evt       (evt)
    );

endmodule
